// ===== hw/rtl/mbe_pkg.sv =====
// Shared types and constants for the Mandelbrot escape-time block.
// Depends on nothing; imported by every module of the block.
package mbe_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 28;
    localparam int ITER_WIDTH  = 16;
    localparam int CFG_WIDTH   = 16;

    // z is kept as signed Q8.FRAC_BITS.
    localparam int Z_WIDTH   = COORD_WIDTH + 4;
    // Multiplier operands are magnitudes no larger than 2.0.
    localparam int MAG_WIDTH = FRAC_BITS + 2;
    localparam int PROD_WIDTH = 2 * MAG_WIDTH;

    localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = ITER_WIDTH'(1000);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] c_re;
        logic signed [COORD_WIDTH-1:0] c_im;
    } in_item_t;

    typedef struct packed {
        logic [ITER_WIDTH-1:0] iteration_count;
        logic                  in_set;
    } out_item_t;

endpackage

// ===== hw/rtl/mandelbrot_escape_iteration.sv =====
// Top level of the Mandelbrot escape-time block: sequencer, z registers, result stage.
// Depends on mbe_pkg and on mbe_mul, the one multiplier shared by every step.
//
//   Channel  Ports                          Direction  Carries
//   -------  -----------------------------  ---------  ------------------------------
//   s_       s_valid, s_ready, s_data       in         point c (c_re, c_im), Q4.28
//   m_       m_valid, m_ready, m_data       out        iteration_count, in_set
//   cfg_     cfg_valid, cfg_ready, cfg_data in         max_iterations
//
// A point stops on the limit or on a part of z above 2.0, or when the sum of squares exceeds 4;
// each iteration is four steps (CHECK, SQ_Y, TEST, UPDATE) around the one shared multiplier.
// After the result is registered the block returns to idle and can take the next request.
// A finished result waits in the output register while the next request runs; if it still
// waits when that point ends, the point holds in its result step until the register is taken.
// Reset (aresetn low, synchronous) empties the output and sets max_iterations to 1000. The
// configuration port is always ready.
module mandelbrot_escape_iteration import mbe_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_WIDTH-1:0] cfg_data
);

    // One iteration walks CHECK -> SQ_Y -> TEST -> UPDATE. The multiplier product
    // is registered and shows up in the cycle after its operands, so each step consumes
    // the product that the previous step requested.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SQ_Y,
        S_TEST,
        S_UPDATE,
        S_RESULT
    } state_t;

    localparam logic [Z_WIDTH-1:0]    TWO_Z      = Z_WIDTH'(2) << FRAC_BITS;
    localparam logic [PROD_WIDTH:0]   FOUR_SQ    = (PROD_WIDTH+1)'(1) << (2*FRAC_BITS + 2);

    state_t                       state_reg, state_next;
    logic signed [COORD_WIDTH-1:0] c_re_reg, c_re_next;
    logic signed [COORD_WIDTH-1:0] c_im_reg, c_im_next;
    logic signed [Z_WIDTH-1:0]    x_reg, x_next;
    logic signed [Z_WIDTH-1:0]    y_reg, y_next;
    logic [ITER_WIDTH-1:0]        n_reg, n_next;
    logic [ITER_WIDTH-1:0]        max_reg, max_next;
    logic [PROD_WIDTH-1:0]        xx_reg, xx_next;
    logic [PROD_WIDTH-1:0]        yy_reg, yy_next;
    logic                         m_valid_reg, m_valid_next;
    out_item_t                    m_data_reg, m_data_next;

    logic [Z_WIDTH-1:0]           mag_x, mag_y;
    logic                         big_z;
    logic [MAG_WIDTH-1:0]         mul_a, mul_b;
    logic [PROD_WIDTH-1:0]        prod;
    logic [PROD_WIDTH:0]          sq_sum;
    logic                         escaped;
    logic                         xy_neg;
    logic signed [Z_WIDTH-1:0]    xx_z, yy_z, xy_mag, xy2_z;
    logic                         out_free;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Magnitudes of z. Either part above 2.0 already means |z|^2 > 4, so the
    // multiplier only ever sees magnitudes of at most 2.0.
    assign mag_x = x_reg[Z_WIDTH-1] ? Z_WIDTH'(-x_reg) : Z_WIDTH'(x_reg);
    assign mag_y = y_reg[Z_WIDTH-1] ? Z_WIDTH'(-y_reg) : Z_WIDTH'(y_reg);
    assign big_z = (mag_x > TWO_Z) || (mag_y > TWO_Z);

    // CHECK asks for x*x, SQ_Y for y*y, TEST for x*y.
    assign mul_a = (state_reg == S_SQ_Y) ? mag_y[MAG_WIDTH-1:0] : mag_x[MAG_WIDTH-1:0];
    assign mul_b = (state_reg == S_CHECK) ? mag_x[MAG_WIDTH-1:0] : mag_y[MAG_WIDTH-1:0];

    mbe_mul u_mul (
        .aclk     (aclk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    // Exact escape test on the full-width squares (prod holds y*y in TEST).
    assign sq_sum  = {1'b0, xx_reg} + {1'b0, prod};
    assign escaped = sq_sum > FOUR_SQ;

    // Update arithmetic; squares are non-negative so truncation is the floor.
    // The cross term 2xy is floored toward minus infinity by rounding the
    // magnitude up when the product is negative and has dropped bits.
    assign xy_neg = x_reg[Z_WIDTH-1] ^ y_reg[Z_WIDTH-1];
    assign xx_z   = Z_WIDTH'(xx_reg >> FRAC_BITS);
    assign yy_z   = Z_WIDTH'(yy_reg >> FRAC_BITS);
    assign xy_mag = Z_WIDTH'(prod >> (FRAC_BITS - 1))
                  + Z_WIDTH'(xy_neg && (|prod[FRAC_BITS-2:0]));
    assign xy2_z  = xy_neg ? Z_WIDTH'(-xy_mag) : xy_mag;

    always_comb begin
        state_next   = state_reg;
        c_re_next    = c_re_reg;
        c_im_next    = c_im_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        n_next       = n_reg;
        max_next     = max_reg;
        xx_next      = xx_reg;
        yy_next      = yy_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            max_next = ITER_WIDTH'(cfg_data);
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    c_re_next  = s_data.c_re;
                    c_im_next  = s_data.c_im;
                    x_next     = '0;
                    y_next     = '0;
                    n_next     = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                // The limit is checked before the escape test, as in the loop header.
                if ((n_reg >= max_reg) || big_z) begin
                    state_next = S_RESULT;
                end else begin
                    state_next = S_SQ_Y;
                end
            end
            S_SQ_Y: begin
                xx_next    = prod;
                state_next = S_TEST;
            end
            S_TEST: begin
                yy_next = prod;
                if (escaped) begin
                    state_next = S_RESULT;
                end else begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                x_next     = xx_z - yy_z + Z_WIDTH'(c_re_reg);
                y_next     = xy2_z + Z_WIDTH'(c_im_reg);
                n_next     = n_reg + ITER_WIDTH'(1);
                state_next = S_CHECK;
            end
            S_RESULT: begin
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.iteration_count = n_reg;
                    m_data_next.in_set          = (n_reg == max_reg);
                    state_next                  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            max_reg     <= MAX_ITER_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            max_reg     <= max_next;
        end
        c_re_reg   <= c_re_next;
        c_im_reg   <= c_im_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        n_reg      <= n_next;
        xx_reg     <= xx_next;
        yy_reg     <= yy_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== hw/rtl/mbe_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on mbe_pkg for the operand and product widths.
module mbe_mul import mbe_pkg::*; (
    input  logic                  aclk,
    input  logic [MAG_WIDTH-1:0]  a,
    input  logic [MAG_WIDTH-1:0]  b,
    output logic [PROD_WIDTH-1:0] prod_reg
);

    // Payload only, so no reset is needed.
    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

endmodule

// ===== hw/rtl/mbe_checker.sv =====
// Port-level checks for the Mandelbrot escape-time block, bound to its top level.
// Depends on mbe_pkg for the payload types and the reset limit.
module mbe_checker import mbe_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input out_item_t            m_data,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_WIDTH-1:0] cfg_data
);

    // Copy of the limit as seen on the configuration port.
    logic [ITER_WIDTH-1:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= MAX_ITER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= ITER_WIDTH'(cfg_data);
        end
    end

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The flag marks exactly the points that ran to the limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.in_set == (m_data.iteration_count == limit_reg)))
        else $error("in_set disagrees with the iteration limit");

    // No point runs past the limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.iteration_count <= limit_reg))
        else $error("iteration count above limit");

    // One point at a time: after a request is taken the input is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    // Reset empties the output.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind mandelbrot_escape_iteration mbe_checker u_mbe_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

// ===== test/mandelbrot_escape_iteration_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mandelbrot_escape_iteration.
// Depends on mbe_pkg for the request and result types and on the block's RTL.
module mandelbrot_escape_iteration_tb;
    import mbe_pkg::*;

    // Run-length guard. The slowest correct run is bounded by three points at the
    // 65535 limit, a handful at the reset limit and five hundred and twelve random
    // points at limits of 150 or less; this is several times that.
    localparam int unsigned CYCLE_LIMIT = 6_000_000;
    // Cycles to wait after the last result.
    localparam int unsigned TAIL_CYCLES = 16;
    // Length of the long receiver hold-off used to back up the block.
    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam int unsigned PHASES = 10;
    localparam int unsigned PHASE_POINTS = 50;
    localparam int unsigned BURST_POINTS = 12;

    // |z|^2 is compared against 4.0 at the full product scale of 2*FRAC_BITS bits.
    localparam logic signed [79:0] ESCAPE_BOUND = 80'sd4 <<< (2 * FRAC_BITS);

    // Random points mostly fall in the window [-2.25, 0.75] x [-1.5, 1.5], where
    // the interesting boundary of the set lies.
    localparam int unsigned RE_SPAN   = 3 << FRAC_BITS;
    localparam int unsigned RE_OFFSET = 9 << (FRAC_BITS - 2);
    localparam int unsigned IM_SPAN   = 3 << FRAC_BITS;
    localparam int unsigned IM_OFFSET = 3 << (FRAC_BITS - 1);

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_WIDTH-1:0] cfg_data  = '0;

    mandelbrot_escape_iteration u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the iteration limit held by the block.
    logic [ITER_WIDTH-1:0]  iter_limit = MAX_ITER_RESET;

    // Results still owed by the block, oldest first.
    out_item_t   owed_escapes[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // Idle rates in percent; each is written by the stimulus process only.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        hold_rx = 1'b0;
    event        rx_holdoff;

    // One row of the directed table. Where typed is set, the expected result is
    // given in the row; otherwise it comes from the shadow model.
    typedef struct packed {
        logic [CFG_WIDTH-1:0]          limit;
        logic signed [COORD_WIDTH-1:0] c_re;
        logic signed [COORD_WIDTH-1:0] c_im;
        logic                          typed;
        logic [ITER_WIDTH-1:0]         count;
        logic                          in_set;
    } dir_row_t;

    localparam int DIR_ROWS = 23;
    dir_row_t directed_points [DIR_ROWS] = '{
        // The origin never escapes and runs to the reset limit.
        '{16'd1000, 32'h00000000, 32'h00000000, 1'b1, 16'd1000, 1'b1},
        // c = -2 keeps |z| at exactly 2, which must not count as an escape.
        '{16'd1000, 32'hE0000000, 32'h00000000, 1'b1, 16'd1000, 1'b1},
        // c = 2 and c = 2i sit on the circle once, then leave on the next update.
        '{16'd1000, 32'h20000000, 32'h00000000, 1'b1, 16'd2,    1'b0},
        '{16'd1000, 32'h00000000, 32'h20000000, 1'b1, 16'd2,    1'b0},
        // Field extremes escape right after the first update.
        '{16'd1000, 32'h80000000, 32'h00000000, 1'b1, 16'd1,    1'b0},
        '{16'd1000, 32'h7FFFFFFF, 32'h00000000, 1'b1, 16'd1,    1'b0},
        '{16'd1000, 32'h00000000, 32'h80000000, 1'b1, 16'd1,    1'b0},
        '{16'd1000, 32'h00000000, 32'h7FFFFFFF, 1'b1, 16'd1,    1'b0},
        '{16'd1000, 32'h80000000, 32'h80000000, 1'b1, 16'd1,    1'b0},
        '{16'd1000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 16'd1,    1'b0},
        // Tiny negative values exercise the floor of negative products.
        '{16'd1000, 32'hFFFFFFFF, 32'h00000001, 1'b0, 16'd0,    1'b0},
        // The cusp at 0.25 and a point near the main bulb.
        '{16'd1000, 32'h04000000, 32'h00000000, 1'b0, 16'd0,    1'b0},
        '{16'd1000, 32'hF4000000, 32'h0199999A, 1'b0, 16'd0,    1'b0},
        // A zero limit does no update at all and reports the point as inside.
        '{16'd0,    32'h00000000, 32'h00000000, 1'b1, 16'd0,    1'b1},
        '{16'd0,    32'h80000000, 32'h7FFFFFFF, 1'b1, 16'd0,    1'b1},
        // With a limit of one the first update always happens; rows with a limit of two follow.
        '{16'd1,    32'h00000000, 32'h00000000, 1'b1, 16'd1,    1'b1},
        '{16'd1,    32'h80000000, 32'h00000000, 1'b1, 16'd1,    1'b1},
        '{16'd2,    32'h7FFFFFFF, 32'h00000000, 1'b1, 16'd1,    1'b0},
        '{16'd2,    32'hE0000000, 32'h00000000, 1'b1, 16'd2,    1'b1},
        // The widest limit, once inside, once escaping and once against the shadow model.
        '{16'hFFFF, 32'h00000000, 32'h00000000, 1'b1, 16'hFFFF, 1'b1},
        '{16'hFFFF, 32'h20000000, 32'h00000000, 1'b1, 16'd2,    1'b0},
        '{16'hFFFF, 32'hF0000000, 32'h04CCCCCD, 1'b0, 16'd0,    1'b0},
        // Alternating bit patterns in both coordinates.
        '{16'd7,    32'h55555555, 32'hAAAAAAAA, 1'b0, 16'd0,    1'b0}
    };

    // Escape-time computation on z in signed Q8.FRAC_BITS. The escape test uses
    // the exact sum of squares; each update floors x*x, y*y and 2*x*y to
    // FRAC_BITS fraction bits before adding c.
    function automatic out_item_t escape_time(in_item_t pt);
        logic signed [Z_WIDTH-1:0] cr;
        logic signed [Z_WIDTH-1:0] ci;
        logic signed [Z_WIDTH-1:0] x;
        logic signed [Z_WIDTH-1:0] y;
        logic signed [Z_WIDTH-1:0] xx;
        logic signed [Z_WIDTH-1:0] yy;
        logic signed [Z_WIDTH-1:0] xy2;
        logic signed [79:0]        px;
        logic signed [79:0]        py;
        logic signed [79:0]        pxy;
        logic [ITER_WIDTH:0]       n;
        logic [ITER_WIDTH:0]       lim;
        logic                      gone;
        out_item_t                 res;
        cr = Z_WIDTH'(pt.c_re);
        ci = Z_WIDTH'(pt.c_im);
        x = '0;
        y = '0;
        n = '0;
        lim = {1'b0, iter_limit};
        gone = 1'b0;
        while (n < lim && !gone) begin
            px = 80'(x) * 80'(x);
            py = 80'(y) * 80'(y);
            if (px + py > ESCAPE_BOUND) begin
                gone = 1'b1;
            end else begin
                pxy = 80'(x) * 80'(y);
                xx  = Z_WIDTH'(px >>> FRAC_BITS);
                yy  = Z_WIDTH'(py >>> FRAC_BITS);
                xy2 = Z_WIDTH'(pxy >>> (FRAC_BITS - 1));
                x = xx - yy + cr;
                y = xy2 + ci;
                n = n + (ITER_WIDTH+1)'(1);
            end
        end
        res.iteration_count = n[ITER_WIDTH-1:0];
        res.in_set = (n == lim);
        return res;
    endfunction

    // Three points in four fall in the window around the set; the rest use the
    // whole field range so that every coordinate bit toggles.
    function automatic in_item_t random_point();
        in_item_t pt;
        if ($urandom_range(0, 3) == 0) begin
            pt.c_re = $urandom;
            pt.c_im = $urandom;
        end else begin
            pt.c_re = $urandom_range(0, RE_SPAN) - RE_OFFSET;
            pt.c_im = $urandom_range(0, IM_SPAN) - IM_OFFSET;
        end
        return pt;
    endfunction

    // Offers one request, optionally after an idle gap. Valid is left high on
    // return, so a following request with no gap keeps it up without a dip.
    task automatic offer_point(in_item_t pt, logic typed, out_item_t typed_res);
        int unsigned gap;
        out_item_t   want;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= pt;
        do @(posedge aclk); while (!s_ready);
        want = escape_time(pt);
        if (typed) begin
            want = typed_res;
        end
        owed_escapes.push_back(want);
    endtask

    // Ends a stream of requests; called in the step of the last acceptance.
    task automatic end_burst();
        s_valid <= 1'b0;
    endtask

    // Waits until the block has handed over every result it owes.
    task automatic wait_drained();
        do @(posedge aclk); while (owed_escapes.size() != 0);
    endtask

    // Writes the iteration limit; only called while the block is idle.
    task automatic write_limit(logic [CFG_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        iter_limit = value;
    endtask

    // Result checker and receiver. Values are sampled at the edge before any
    // update of that edge lands, so a result counts when valid and ready were
    // both high during the cycle that just ended.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_escapes.size() == 0) begin
                mismatches++;
                $display("%0t: result with none owed: count %0d in_set %0d",
                         $time, m_data.iteration_count, m_data.in_set);
            end else begin
                want = owed_escapes.pop_front();
                if (m_data.iteration_count !== want.iteration_count) begin
                    mismatches++;
                    $display("%0t: iteration_count expected %0d got %0d",
                             $time, want.iteration_count, m_data.iteration_count);
                end
                if (m_data.in_set !== want.in_set) begin
                    mismatches++;
                    $display("%0t: in_set expected %0d got %0d",
                             $time, want.in_set, m_data.in_set);
                end
            end
        end
        m_ready <= !hold_rx && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // The long hold-off runs in its own process and counts its own cycles.
    initial begin
        forever begin
            @(rx_holdoff);
            @(posedge aclk);
            hold_rx <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge aclk);
            hold_rx <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        out_item_t   row_res;
        in_item_t    row_pt;
        int unsigned phase;
        int unsigned k;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table. The first rows run on the limit left by reset; a
        // limit change waits for the block to go idle before the write.
        for (k = 0; k < DIR_ROWS; k++) begin
            if (directed_points[k].limit != iter_limit) begin
                end_burst();
                wait_drained();
                write_limit(directed_points[k].limit);
            end
            row_pt.c_re = directed_points[k].c_re;
            row_pt.c_im = directed_points[k].c_im;
            row_res.iteration_count = directed_points[k].count;
            row_res.in_set = directed_points[k].in_set;
            offer_point(row_pt, directed_points[k].typed, row_res);
        end
        end_burst();
        wait_drained();

        // Back-pressure: the receiver holds off while the sender keeps offering,
        // so the block fills its output register and stops taking requests.
        write_limit(CFG_WIDTH'(20));
        -> rx_holdoff;
        for (k = 0; k < BURST_POINTS; k++) begin
            offer_point(random_point(), 1'b0, '0);
        end
        end_burst();
        wait_drained();

        // Random phases, each with its own limit and idling pattern. One phase
        // runs with a zero limit. Halfway through a phase the sender pauses
        // until every owed result has come back.
        for (phase = 0; phase < PHASES; phase++) begin
            end_burst();
            wait_drained();
            if (phase == 4) begin
                write_limit('0);
            end else begin
                write_limit(CFG_WIDTH'($urandom_range(1, 150)));
            end
            case (phase % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct = 48;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 48;
                end
                default: begin
                    tx_idle_pct = 21;
                    rx_stall_pct <= 21;
                end
            endcase
            for (k = 0; k < PHASE_POINTS; k++) begin
                offer_point(random_point(), 1'b0, '0);
                if (k == PHASE_POINTS / 2) begin
                    end_burst();
                    wait_drained();
                end
            end
        end

        end_burst();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && owed_escapes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
